@@ rtl/mlfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and defaults for the multilevel feedback queue.
// Holds the operation codes, the field widths and the parameter defaults.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam int NUM_LEVELS_DEF  = 5;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PID_COUNT_DEF   = 256;

	localparam int PID_W   = 8;
	localparam int LEVEL_W = 3;
	localparam int WAIT_W  = 7;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_NEXT  = 2'd1,
		OP_BOOST = 2'd2,
		OP_FLUSH = 2'd3
	} op_t;

endpackage

@@ rtl/mlfq_ram.sv @@
// ----------------------------------------------------------------------------
// mlfq_ram: simple dual-port memory.
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mlfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/multilevel_feedback_queue_top.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_top: feedback queue scheduler of process ids.
// A small sequencer drives one queue memory and one id level table.
// ----------------------------------------------------------------------------
// Usage: a command beat (operation, pid) enters on in_valid/in_stall and
// exactly one result beat leaves on out_valid/out_stall for every command.
// A beat moves at a rising edge where valid is high and stall is low.
// The block works on one command at a time and holds in_stall high meanwhile.
// Steps per command, from accept to result ready:
//   flush: empties all levels.  add of id 0: pushed straight onto level 0.
//   take next: pops the head of the first non-empty level, if any.  add of
//   another id: reduced into the level table by subtracting PID_COUNT, its
//   table level updated, then pushed.  boost: the level table is swept to
//   zero, then every id on levels one and up is moved onto level 0.
// The queue memory and level table each have one read and one write port.
// The result sits in an output register, so the next command is taken while
// a finished result waits; a stalled receiver only holds back the following
// result, and the sequencer waits in its final state until the register frees.
// After reset the level table is swept to zero with in_stall high; the queue
// memory is never cleared, since only entries within a level's count are
// ever read.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_top #(
	parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF,
	parameter int QUEUE_DEPTH = mlfq_pkg::QUEUE_DEPTH_DEF,
	parameter int PID_COUNT   = mlfq_pkg::PID_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mlfq_pkg::op_t                  operation,
	input  logic [mlfq_pkg::PID_W-1:0]     pid,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mlfq_pkg::PID_W-1:0]     out_pid,
	output logic                           found,
	output logic [mlfq_pkg::LEVEL_W-1:0]   assigned_level,
	output logic                           dropped,
	output logic [mlfq_pkg::WAIT_W-1:0]    waiting_count
);

	import mlfq_pkg::*;

	localparam int LW  = $clog2(NUM_LEVELS);
	localparam int LW1 = $clog2(NUM_LEVELS + 1);
	localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int TW  = $clog2(NUM_LEVELS * QUEUE_DEPTH + 1);
	localparam int AW  = $clog2(NUM_LEVELS * QUEUE_DEPTH);
	localparam int IW  = $clog2(PID_COUNT);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_CLEAR  = 11'b000_0000_0010,
		ST_REDUCE = 11'b000_0000_0100,
		ST_TABUPD = 11'b000_0000_1000,
		ST_PUSH   = 11'b000_0001_0000,
		ST_NEXTRD = 11'b000_0010_0000,
		ST_NEXTWR = 11'b000_0100_0000,
		ST_BCLR   = 11'b000_1000_0000,
		ST_MVRD   = 11'b001_0000_0000,
		ST_MVWR   = 11'b010_0000_0000,
		ST_FIN    = 11'b100_0000_0000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q   [NUM_LEVELS];
	logic [HW-1:0]     head_q  [NUM_LEVELS];
	logic [TW-1:0]     total_q;
	logic [IW-1:0]     sweep_q;
	logic [PID_W-1:0]  pid_q;
	logic [PID_W-1:0]  idx_q;
	logic [LEVEL_W-1:0] level_q;
	logic [LW1-1:0]    lv_q;
	logic [PID_W-1:0]  took_q;
	logic              found_q;
	logic              drop_q;

	logic              out_valid_q;
	logic [PID_W-1:0]  out_pid_q;
	logic              out_found_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic              out_drop_q;
	logic [WAIT_W-1:0] out_wait_q;

	// Highest-priority non-empty level.
	logic [LW-1:0] first_lv;
	logic          any_ready;

	always_comb begin
		first_lv  = '0;
		any_ready = 1'b0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				first_lv  = LW'(i);
				any_ready = 1'b1;
			end
		end
	end

	// Queue memory ports.
	logic [LW-1:0]    rd_lv;
	logic [LW-1:0]    wr_lv;
	logic [HW-1:0]    wr_slot;
	logic [AW-1:0]    q_raddr;
	logic [AW-1:0]    q_waddr;
	logic             q_we;
	logic [PID_W-1:0] q_wdata;
	logic [PID_W-1:0] q_rdata;
	logic             wr_full;
	int               tail_sum;

	always_comb begin
		rd_lv    = (state_q == ST_NEXTRD) ? first_lv : lv_q[LW-1:0];
		wr_lv    = (state_q == ST_PUSH) ? level_q[LW-1:0] : '0;
		tail_sum = int'(head_q[wr_lv]) + int'(cnt_q[wr_lv]);
		if (tail_sum >= QUEUE_DEPTH) begin
			tail_sum = tail_sum - QUEUE_DEPTH;
		end
		wr_slot  = HW'(tail_sum);
		wr_full  = (int'(cnt_q[wr_lv]) >= QUEUE_DEPTH);
		q_raddr  = AW'(int'(rd_lv) * QUEUE_DEPTH + int'(head_q[rd_lv]));
		q_waddr  = AW'(int'(wr_lv) * QUEUE_DEPTH + int'(wr_slot));
		q_we     = ((state_q == ST_PUSH) || (state_q == ST_MVWR)) && !wr_full;
		q_wdata  = (state_q == ST_PUSH) ? pid_q : q_rdata;
	end

	mlfq_ram #(
		.WIDTH (PID_W),
		.DEPTH (NUM_LEVELS * QUEUE_DEPTH),
		.AW    (AW)
	) u_queue_mem (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// Level table. A stored level of zero stands for both an unseen id and
	// one reset by a boost: both are queued at level one on their next add.
	logic          t_we;
	logic [IW-1:0] t_waddr;
	logic [LW-1:0] t_wdata;
	logic [LW-1:0] t_rdata;
	logic [LW-1:0] new_lv;

	always_comb begin
		if (t_rdata == '0) begin
			new_lv = LW'(1);
		end else if (int'(t_rdata) < NUM_LEVELS - 1) begin
			new_lv = t_rdata + LW'(1);
		end else begin
			new_lv = t_rdata;
		end
		t_we    = (state_q == ST_CLEAR) || (state_q == ST_BCLR) || (state_q == ST_TABUPD);
		t_waddr = (state_q == ST_TABUPD) ? IW'(idx_q) : sweep_q;
		t_wdata = (state_q == ST_TABUPD) ? new_lv : '0;
	end

	mlfq_ram #(
		.WIDTH (LW),
		.DEPTH (PID_COUNT),
		.AW    (IW)
	) u_level_tab (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (IW'(idx_q)),
		.rdata (t_rdata)
	);

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Result valid: set when the sequencer hands over a result, cleared when
	// the receiver takes the beat and nothing new replaces it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			total_q     <= '0;
			lv_q        <= '0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_CLEAR, ST_BCLR: begin
					if (sweep_q == IW'(PID_COUNT - 1)) begin
						sweep_q <= '0;
						lv_q    <= LW1'(1);
						state_q <= (state_q == ST_CLEAR) ? ST_IDLE : ST_MVRD;
					end else begin
						sweep_q <= sweep_q + IW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						pid_q   <= pid;
						idx_q   <= pid;
						level_q <= '0;
						took_q  <= '0;
						found_q <= 1'b0;
						drop_q  <= 1'b0;
						case (operation)
							OP_ADD:   state_q <= (pid == '0) ? ST_PUSH : ST_REDUCE;
							OP_NEXT:  state_q <= ST_NEXTRD;
							OP_BOOST: state_q <= ST_BCLR;
							OP_FLUSH: begin
								total_q <= '0;
								for (int i = 0; i < NUM_LEVELS; i++) begin
									cnt_q[i]  <= '0;
									head_q[i] <= '0;
								end
								state_q <= ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_REDUCE: begin
					// Bring the id into table range one subtraction at a time.
					if (int'(idx_q) >= PID_COUNT) begin
						idx_q <= idx_q - PID_W'(PID_COUNT);
					end else begin
						state_q <= ST_TABUPD;
					end
				end
				ST_TABUPD: begin
					level_q <= LEVEL_W'(new_lv);
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (wr_full) begin
						drop_q <= 1'b1;
					end else begin
						cnt_q[wr_lv] <= cnt_q[wr_lv] + CW'(1);
						total_q      <= total_q + TW'(1);
					end
					state_q <= ST_FIN;
				end
				ST_NEXTRD: begin
					if (any_ready) begin
						head_q[rd_lv] <= (int'(head_q[rd_lv]) == QUEUE_DEPTH - 1) ?
							'0 : head_q[rd_lv] + HW'(1);
						cnt_q[rd_lv]  <= cnt_q[rd_lv] - CW'(1);
						total_q       <= total_q - TW'(1);
						state_q       <= ST_NEXTWR;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_NEXTWR: begin
					took_q  <= q_rdata;
					found_q <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_MVRD: begin
					if (int'(lv_q) >= NUM_LEVELS) begin
						state_q <= ST_FIN;
					end else if (cnt_q[rd_lv] == '0) begin
						lv_q <= lv_q + LW1'(1);
					end else begin
						head_q[rd_lv] <= (int'(head_q[rd_lv]) == QUEUE_DEPTH - 1) ?
							'0 : head_q[rd_lv] + HW'(1);
						cnt_q[rd_lv]  <= cnt_q[rd_lv] - CW'(1);
						state_q       <= ST_MVWR;
					end
				end
				ST_MVWR: begin
					// The popped id lands on the tail of level zero, or is lost.
					if (wr_full) begin
						drop_q  <= 1'b1;
						total_q <= total_q - TW'(1);
					end else begin
						cnt_q[wr_lv] <= cnt_q[wr_lv] + CW'(1);
					end
					state_q <= ST_MVRD;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_pid_q   <= took_q;
			out_found_q <= found_q;
			out_level_q <= level_q;
			out_drop_q  <= drop_q;
			out_wait_q  <= WAIT_W'(total_q);
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign out_pid        = out_pid_q;
	assign found          = out_found_q;
	assign assigned_level = out_level_q;
	assign dropped        = out_drop_q;
	assign waiting_count  = out_wait_q;

endmodule
